>>> rtl/core/rcmix_pkg.sv
package rcmix_pkg;

    localparam int NCH   = 12;
    localparam int NLANE = 6;

    localparam logic [11:0] CH_MIN      = 12'd172;
    localparam logic [11:0] CH_MAX      = 12'd1811;
    localparam logic [11:0] ELEVON_MID  = 12'd992;
    localparam logic [7:0]  TRIM_CENTRE = 8'd127;

    localparam logic [2:0] MODE_RTAE   = 3'd0;
    localparam logic [2:0] MODE_AETR   = 3'd1;
    localparam logic [2:0] MODE_ELEVON = 3'd2;
    localparam logic [2:0] MODE_DRIFT  = 3'd3;
    localparam logic [2:0] MODE_CAL    = 3'd4;

    localparam logic [2:0] CFG_MODE          = 3'd0;
    localparam logic [2:0] CFG_TRIM_THROTTLE = 3'd1;
    localparam logic [2:0] CFG_TRIM_YAW      = 3'd2;
    localparam logic [2:0] CFG_TRIM_PITCH    = 3'd3;
    localparam logic [2:0] CFG_TRIM_ROLL     = 3'd4;

    localparam logic [3:0] IDX_BACK = 4'd14;
    localparam logic [3:0] IDX_OK   = 4'd15;

    localparam logic [2:0] LANE_THR  = 3'd0;
    localparam logic [2:0] LANE_YAW  = 3'd1;
    localparam logic [2:0] LANE_PIT  = 3'd2;
    localparam logic [2:0] LANE_ROL  = 3'd3;
    localparam logic [2:0] LANE_AUX2 = 3'd4;
    localparam logic [2:0] LANE_AUX3 = 3'd5;

    // per-lane map constants; recip is floor(2^32 / dvs)
    typedef struct packed {
        logic [11:0] base;
        logic        inv;
        logic [10:0] span;
        logic [12:0] dvs;
        logic [20:0] recip;
        logic [10:0] lo;
        logic        trim_en;
    } lane_cfg_t;

    typedef struct packed {
        logic [11:0] adc_throttle;
        logic [11:0] adc_yaw;
        logic [11:0] adc_pitch;
        logic [11:0] adc_roll;
        logic        aux_one;
        logic [11:0] aux_two_adc;
        logic [11:0] aux_three_adc;
        logic        aux_four;
        logic        aux_five;
        logic        aux_six;
        logic        button_back;
        logic        button_ok;
    } sample_t;

    typedef struct packed {
        logic [NCH-1:0][11:0] val;
        logic [NCH-1:0][3:0]  idx;
        logic [3:0]           count;
        logic                 raw;
    } frame_t;

    function automatic lane_cfg_t lane_cfg(input logic [2:0] lane, input logic drift);
        lane_cfg_t c;
        c.base    = 12'd0;
        c.inv     = 1'b0;
        c.span    = 11'd1639;
        c.dvs     = 13'd4096;
        c.recip   = 21'd1048576;
        c.lo      = 11'd172;
        c.trim_en = 1'b0;
        case (lane)
            LANE_THR:
            begin
                c.base    = 12'd650;
                c.dvs     = 13'd2855;
                c.recip   = 21'd1504366;
                c.trim_en = 1'b1;
            end
            LANE_YAW:
            begin
                c.base    = 12'd3777;
                c.inv     = 1'b1;
                c.dvs     = 13'd3227;
                c.recip   = 21'd1330947;
                c.trim_en = 1'b1;
            end
            LANE_PIT:
            begin
                c.base    = 12'd3705;
                c.inv     = 1'b1;
                c.dvs     = 13'd3340;
                c.recip   = 21'd1285918;
                c.trim_en = 1'b1;
                if (drift)
                begin
                    c.span = 11'd289;
                    c.lo   = 11'd822;
                end
            end
            LANE_ROL:
            begin
                c.base    = 12'd580;
                c.dvs     = 13'd2965;
                c.recip   = 21'd1448555;
                c.trim_en = 1'b1;
            end
            default:
            begin
                c.base = 12'd0;
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/rcmix_lane.sv
module rcmix_lane
    import rcmix_pkg::*;
(
    input  logic        clk,
    input  lane_cfg_t   cfg,
    input  logic [7:0]  trim,
    input  logic [11:0] x,
    output logic [10:0] value
);

    localparam logic signed [13:0] CLAMP_LO = 14'(CH_MIN);
    localparam logic signed [13:0] CLAMP_HI = 14'(CH_MAX);

    logic signed [12:0] diff;
    logic signed [23:0] prod;
    logic [22:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;

    logic [43:0] scaled;
    logic [11:0] qest_reg, qest_next;
    logic [22:0] mag_b_reg;
    logic        neg_b_reg;

    logic [24:0] qd;
    logic [24:0] rem;
    logic [11:0] q_reg, q_next;
    logic        neg_c_reg;

    logic signed [13:0] sq;
    logic signed [9:0]  toff;
    logic signed [13:0] sum;
    logic [10:0] value_reg, value_next;

    // product of offset and span, split into magnitude and sign
    always_comb
    begin
        if (cfg.inv)
            diff = $signed({1'b0, cfg.base}) - $signed({1'b0, x});
        else
            diff = $signed({1'b0, x}) - $signed({1'b0, cfg.base});
        prod     = diff * $signed({1'b0, cfg.span});
        neg_next = prod[23];
        mag_next = prod[23] ? 23'(-prod) : prod[22:0];
    end

    // reciprocal estimate, at most one short of the true quotient
    always_comb
    begin
        scaled    = 44'(mag_reg) * 44'(cfg.recip);
        qest_next = scaled[43:32];
    end

    // one correction step
    always_comb
    begin
        qd  = 25'(qest_reg) * 25'(cfg.dvs);
        rem = {2'b00, mag_b_reg} - qd;
        if (rem >= {12'd0, cfg.dvs})
            q_next = qest_reg + 12'd1;
        else
            q_next = qest_reg;
    end

    // sign and offset; trim and clamp on the trim-enabled lanes only
    always_comb
    begin
        sq   = neg_c_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        toff = ($signed({2'b00, trim}) - $signed({2'b00, TRIM_CENTRE})) <<< 1;
        sum  = sq + $signed({3'b000, cfg.lo}) + (cfg.trim_en ? 14'(toff) : 14'sd0);
        value_next = sum[10:0];
        if (cfg.trim_en)
        begin
            if (sum < CLAMP_LO)
                value_next = CH_MIN[10:0];
            else if (sum > CLAMP_HI)
                value_next = CH_MAX[10:0];
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        qest_reg  <= qest_next;
        mag_b_reg <= mag_reg;
        neg_b_reg <= neg_reg;
        q_reg     <= q_next;
        neg_c_reg <= neg_b_reg;
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/core/rcmix_merge.sv
module rcmix_merge
    import rcmix_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   take,
    input  logic [2:0]             mode,
    input  sample_t                sample,
    input  logic [NLANE-1:0][10:0] lane_val,
    output frame_t                 frame,
    output logic                   frame_valid
);

    logic   pend_valid_reg, pend_valid_next;
    frame_t frame_reg, frame_next;

    logic [11:0] thr, yaw, pit, rol;
    logic signed [12:0] ev_a, ev_b;

    function automatic logic [11:0] sw_val(input logic level);
        return level ? CH_MAX : CH_MIN;
    endfunction

    function automatic logic [11:0] ev_clamp(input logic signed [12:0] v);
        logic [11:0] r;
        r = v[11:0];
        if (v < $signed({1'b0, CH_MIN}))
            r = CH_MIN;
        else if (v > $signed({1'b0, CH_MAX}))
            r = CH_MAX;
        return r;
    endfunction

    always_comb
    begin
        thr  = {1'b0, lane_val[LANE_THR]};
        yaw  = {1'b0, lane_val[LANE_YAW]};
        pit  = {1'b0, lane_val[LANE_PIT]};
        rol  = {1'b0, lane_val[LANE_ROL]};
        ev_a = $signed({1'b0, rol}) + $signed({1'b0, pit}) - $signed({1'b0, ELEVON_MID});
        ev_b = $signed({1'b0, ELEVON_MID}) - $signed({1'b0, rol}) + $signed({1'b0, pit});

        for (int i = 0; i < NCH; i++)
            frame_next.idx[i] = 4'(i);
        frame_next.idx[10] = IDX_BACK;
        frame_next.idx[11] = IDX_OK;

        frame_next.raw    = 1'b0;
        frame_next.val[0] = yaw;
        frame_next.val[1] = thr;
        frame_next.val[2] = rol;
        frame_next.val[3] = pit;
        frame_next.val[4] = sw_val(sample.aux_one);
        frame_next.val[5] = {1'b0, lane_val[LANE_AUX2]};
        frame_next.val[6] = {1'b0, lane_val[LANE_AUX3]};
        frame_next.val[7] = sw_val(sample.aux_four);
        frame_next.val[8] = sw_val(sample.aux_five);
        frame_next.val[9] = sw_val(sample.aux_six);
        frame_next.val[10] = sw_val(sample.button_back);
        frame_next.val[11] = sw_val(sample.button_ok);

        case (mode)
            MODE_RTAE, MODE_DRIFT:
            begin
                frame_next.count = 4'd12;
            end
            MODE_AETR:
            begin
                frame_next.val[0] = rol;
                frame_next.val[1] = pit;
                frame_next.val[2] = thr;
                frame_next.val[3] = yaw;
                frame_next.count  = 4'd10;
            end
            MODE_ELEVON:
            begin
                frame_next.val[2] = ev_clamp(ev_a);
                frame_next.val[3] = ev_clamp(ev_b);
                frame_next.count  = 4'd10;
            end
            MODE_CAL:
            begin
                frame_next.val[0] = sample.adc_throttle;
                frame_next.val[1] = sample.adc_yaw;
                frame_next.val[2] = sample.adc_pitch;
                frame_next.val[3] = sample.adc_roll;
                frame_next.raw    = 1'b1;
                frame_next.count  = 4'd4;
            end
            default:
            begin
                frame_next.count = 4'd0;
            end
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (load)
            pend_valid_next = 1'b1;
        else if (take)
            pend_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= pend_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= frame_next;
    end

    assign frame       = frame_reg;
    assign frame_valid = pend_valid_reg;

endmodule

>>> rtl/core/rcmix_emit.sv
module rcmix_emit
    import rcmix_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      frame,
    input  logic        frame_valid,
    output logic        take,
    output logic        result_valid,
    output logic [3:0]  channel_index,
    output logic [11:0] channel_value,
    output logic        raw_reading,
    output logic        last_channel
);

    logic [3:0]           cnt_reg, cnt_next;
    logic [NCH-1:0][11:0] val_reg, val_next;
    logic [NCH-1:0][3:0]  idx_reg, idx_next;
    logic                 raw_reg, raw_next;

    // a waiting frame moves in on the last result of the one going out, or at once when idle
    assign take = frame_valid && (cnt_reg <= 4'd1);

    always_comb
    begin
        cnt_next = cnt_reg;
        val_next = val_reg;
        idx_next = idx_reg;
        raw_next = raw_reg;
        if (take)
        begin
            cnt_next = frame.count;
            val_next = frame.val;
            idx_next = frame.idx;
            raw_next = frame.raw;
        end
        else if (cnt_reg != 4'd0)
        begin
            cnt_next = cnt_reg - 4'd1;
            val_next = val_reg >> 12;
            idx_next = idx_reg >> 4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        idx_reg <= idx_next;
        raw_reg <= raw_next;
    end

    assign result_valid  = (cnt_reg != 4'd0);
    assign channel_index = idx_reg[0];
    assign channel_value = val_reg[0];
    assign raw_reading   = raw_reg;
    assign last_channel  = (cnt_reg == 4'd1);

endmodule

>>> rtl/core/rc_stick_channel_mixer.sv
// channel        handshake                    payload
// sample set     start / busy                 adc_*, aux_*, button_*
// configuration  cfg_valid / cfg_ready        cfg_index, cfg_data
// results        result_valid (strobe only)   channel_index, channel_value,
//                                             raw_reading, last_channel
//
// first result leaves once the set has passed the lane stages, the frame register and
// the output shifter load, then one per cycle; a new set is taken once the previous
// one has reached the output shifter, while that one is still being sent: a set is
// 12 results in rtae and drift, 10 in aetr and elevon, 4 in calibration, 0 in unused modes
// the six map lanes (multiply, reciprocal, correction, trim) are 4 stages deep
// reset clears the pipeline and loads the trims to centre, mode to rtae
// results cannot be held off by the receiver; cfg_ready is always high
module rc_stick_channel_mixer
    import rcmix_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] adc_throttle,
    input  logic [11:0] adc_yaw,
    input  logic [11:0] adc_pitch,
    input  logic [11:0] adc_roll,
    input  logic        aux_one,
    input  logic [11:0] aux_two_adc,
    input  logic [11:0] aux_three_adc,
    input  logic        aux_four,
    input  logic        aux_five,
    input  logic        aux_six,
    input  logic        button_back,
    input  logic        button_ok,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        result_valid,
    output logic [3:0]  channel_index,
    output logic [11:0] channel_value,
    output logic        raw_reading,
    output logic        last_channel
);

    logic [2:0] mode_reg, mode_next;
    logic [7:0] trim_thr_reg, trim_thr_next;
    logic [7:0] trim_yaw_reg, trim_yaw_next;
    logic [7:0] trim_pit_reg, trim_pit_next;
    logic [7:0] trim_rol_reg, trim_rol_next;

    sample_t    sample_reg;
    logic [4:0] stage_v_reg, stage_v_next;
    logic       accept;
    logic       drift;

    logic [NLANE-1:0][11:0] lane_x;
    logic [NLANE-1:0][7:0]  lane_trim;
    logic [NLANE-1:0][10:0] lane_val;

    frame_t frame;
    logic   frame_valid;
    logic   take;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign busy      = (stage_v_reg != 5'd0) || frame_valid;
    assign drift     = (mode_reg == MODE_DRIFT);

    always_comb
    begin
        mode_next     = mode_reg;
        trim_thr_next = trim_thr_reg;
        trim_yaw_next = trim_yaw_reg;
        trim_pit_next = trim_pit_reg;
        trim_rol_next = trim_rol_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:          mode_next     = cfg_data[2:0];
                CFG_TRIM_THROTTLE: trim_thr_next = cfg_data;
                CFG_TRIM_YAW:      trim_yaw_next = cfg_data;
                CFG_TRIM_PITCH:    trim_pit_next = cfg_data;
                CFG_TRIM_ROLL:     trim_rol_next = cfg_data;
                default:           mode_next     = mode_reg;
            endcase
        end
    end

    // the captured set stays put while it is in flight, so no delay line
    assign stage_v_next = {stage_v_reg[3:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RTAE;
            trim_thr_reg <= TRIM_CENTRE;
            trim_yaw_reg <= TRIM_CENTRE;
            trim_pit_reg <= TRIM_CENTRE;
            trim_rol_reg <= TRIM_CENTRE;
            stage_v_reg  <= 5'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            trim_thr_reg <= trim_thr_next;
            trim_yaw_reg <= trim_yaw_next;
            trim_pit_reg <= trim_pit_next;
            trim_rol_reg <= trim_rol_next;
            stage_v_reg  <= stage_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.adc_throttle  <= adc_throttle;
            sample_reg.adc_yaw       <= adc_yaw;
            sample_reg.adc_pitch     <= adc_pitch;
            sample_reg.adc_roll      <= adc_roll;
            sample_reg.aux_one       <= aux_one;
            sample_reg.aux_two_adc   <= aux_two_adc;
            sample_reg.aux_three_adc <= aux_three_adc;
            sample_reg.aux_four      <= aux_four;
            sample_reg.aux_five      <= aux_five;
            sample_reg.aux_six       <= aux_six;
            sample_reg.button_back   <= button_back;
            sample_reg.button_ok     <= button_ok;
        end
    end

    always_comb
    begin
        lane_x[LANE_THR]     = sample_reg.adc_throttle;
        lane_x[LANE_YAW]     = sample_reg.adc_yaw;
        lane_x[LANE_PIT]     = sample_reg.adc_pitch;
        lane_x[LANE_ROL]     = sample_reg.adc_roll;
        lane_x[LANE_AUX2]    = sample_reg.aux_two_adc;
        lane_x[LANE_AUX3]    = sample_reg.aux_three_adc;
        lane_trim[LANE_THR]  = trim_thr_reg;
        lane_trim[LANE_YAW]  = trim_yaw_reg;
        lane_trim[LANE_PIT]  = trim_pit_reg;
        lane_trim[LANE_ROL]  = trim_rol_reg;
        lane_trim[LANE_AUX2] = TRIM_CENTRE;
        lane_trim[LANE_AUX3] = TRIM_CENTRE;
    end

    for (genvar g = 0; g < NLANE; g++)
    begin : g_lane
        rcmix_lane u_lane (
            .clk   (clk),
            .cfg   (lane_cfg(3'(g), drift)),
            .trim  (lane_trim[g]),
            .x     (lane_x[g]),
            .value (lane_val[g])
        );
    end

    rcmix_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (stage_v_reg[4]),
        .take        (take),
        .mode        (mode_reg),
        .sample      (sample_reg),
        .lane_val    (lane_val),
        .frame       (frame),
        .frame_valid (frame_valid)
    );

    rcmix_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .frame_valid   (frame_valid),
        .take          (take),
        .result_valid  (result_valid),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .raw_reading   (raw_reading),
        .last_channel  (last_channel)
    );

endmodule

>>> rtl/core/rcmix_checker.sv
module rcmix_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [3:0]  channel_index,
    input logic [11:0] channel_value,
    input logic        raw_reading,
    input logic        last_channel
);

    // a taken set blocks the next one straight away
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a sample set was taken");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        last_channel |-> result_valid)
        else $error("last_channel without a result");

    // results of one set come back to back in channel order, 9 jumps to 14
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_channel |=> result_valid &&
            ((channel_index == $past(channel_index) + 4'd1) ||
             ($past(channel_index) == 4'd9 && channel_index == 4'd14)))
        else $error("channel sequence broken");

    a_mixed_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !raw_reading |-> channel_value >= 12'd172 &&
            channel_value <= 12'd1811)
        else $error("mixed channel outside its range");

    a_raw_sticks_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && raw_reading |-> channel_index <= 4'd3)
        else $error("raw reading on a non-stick channel");

endmodule

bind rc_stick_channel_mixer rcmix_checker u_checker (.*);
